@@ hdl/i2p_pkg.sv @@
package i2p_pkg;

  // default operator stack depth
  localparam int unsigned StackDepth = 32;

  // character codes
  localparam logic [7:0] ChCaret = 8'h5E;
  localparam logic [7:0] ChAmp   = 8'h26;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChPct   = 8'h25;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChOpen  = 8'h28;
  localparam logic [7:0] ChClose = 8'h29;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowZ  = 8'h7A;

  typedef enum logic [1:0] {
    ErrNone      = 2'd0,
    ErrOverflow  = 2'd1,
    ErrUnmatched = 2'd2
  } err_e;

  // how the held character is handled
  typedef enum logic [1:0] {
    ChrLetter,
    ChrPush,
    ChrClose,
    ChrOper
  } chr_kind_e;

  typedef struct packed {
    logic load;       // take a new input word
    logic push;       // push held character
    logic pop;        // drop top of stack
    logic emit;       // emit a character
    logic emit_top;   // emitted character is the top of stack
    logic unmatched;  // flag unmatched close paren
    logic fin;        // close the item
  } cmd_t;

  typedef struct packed {
    chr_kind_e kind;
    logic      last;
    logic      cnt_zero;
    logic      top_open;
    logic      prec_ge;
    logic      pend_valid;
    logic      out_free;
    logic      fin_more;
  } stat_t;

  function automatic logic [2:0] prec_of(logic [7:0] c);
    logic [2:0] p;
    case (c)
      ChCaret, ChAmp:         p = 3'd4;
      ChStar, ChSlash, ChPct: p = 3'd3;
      ChPlus, ChMinus:        p = 3'd2;
      default:                p = 3'd1;
    endcase
    return p;
  endfunction

  function automatic chr_kind_e kind_of(logic [7:0] c);
    chr_kind_e k;
    if (c >= ChLowA && c <= ChLowZ) begin
      k = ChrLetter;
    end else begin
      case (c)
        ChOpen, ChCaret: k = ChrPush;
        ChClose:         k = ChrClose;
        default:         k = ChrOper;
      endcase
    end
    return k;
  endfunction

endpackage

@@ hdl/i2p_dp.sv @@
module i2p_dp #(
  parameter int unsigned StackDepth = i2p_pkg::StackDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [7:0]      in_char_i,
  input  logic            in_last_i,
  input  i2p_pkg::cmd_t   cmd_i,
  output i2p_pkg::stat_t  stat_o,
  input  logic            out_stall_i,
  output logic            out_valid_o,
  output logic [7:0]      out_char_o,
  output logic            char_valid_o,
  output logic            run_last_o,
  output logic            expr_done_o,
  output logic [1:0]      err_code_o
);

  localparam int unsigned CntW  = $clog2(StackDepth + 1);
  localparam int unsigned AddrW = $clog2(StackDepth);

  logic [7:0]         held_q;
  logic               last_q;
  logic [CntW-1:0]    cnt_q;
  logic [CntW-1:0]    cnt_m2;
  logic [7:0]         top_q;
  logic [7:0]         mem [StackDepth];
  i2p_pkg::err_e      err_q;
  logic               pend_valid_q, pend_valid_d;
  logic [7:0]         pend_char_q, pend_char_d;
  logic               full;
  logic               do_push;
  logic [7:0]         emit_char;
  logic               out_free;

  logic               out_valid_q;
  logic [7:0]         out_char_q, out_char_d;
  logic               char_valid_q, char_valid_d;
  logic               fin_q, fin_d;
  logic               done_q;
  i2p_pkg::err_e      err_out_q, err_out_d;
  logic               out_wr;

  assign full      = (cnt_q == CntW'(StackDepth));
  assign do_push   = cmd_i.push && !full;
  assign cnt_m2    = cnt_q - CntW'(2);
  assign emit_char = cmd_i.emit_top ? top_q : held_q;
  assign out_free  = !out_valid_q || !out_stall_i;

  // held word and stack storage
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      held_q <= in_char_i;
      last_q <= in_last_i;
    end
    if (do_push) begin
      mem[cnt_q[AddrW-1:0]] <= held_q;
      top_q <= held_q;
    end else if (cmd_i.pop) begin
      top_q <= mem[cnt_m2[AddrW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      err_q        <= i2p_pkg::ErrNone;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (do_push) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (cmd_i.pop) begin
        cnt_q <= cnt_q - CntW'(1);
      end
      if (cmd_i.load) begin
        err_q <= i2p_pkg::ErrNone;
      end else if (cmd_i.push && full) begin
        err_q <= i2p_pkg::ErrOverflow;
      end else if (cmd_i.unmatched) begin
        err_q <= i2p_pkg::ErrUnmatched;
      end
      pend_valid_q <= pend_valid_d;
      if (out_wr) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // one word is held back so the final one of an item can carry the flags
  always_comb begin
    out_wr       = 1'b0;
    out_char_d   = 8'h00;
    char_valid_d = 1'b0;
    fin_d        = 1'b0;
    pend_valid_d = pend_valid_q;
    pend_char_d  = pend_char_q;
    if (cmd_i.emit) begin
      if (pend_valid_q) begin
        out_wr       = 1'b1;
        out_char_d   = pend_char_q;
        char_valid_d = 1'b1;
      end
      pend_valid_d = 1'b1;
      pend_char_d  = emit_char;
    end else if (cmd_i.fin) begin
      if (pend_valid_q) begin
        out_wr       = 1'b1;
        out_char_d   = pend_char_q;
        char_valid_d = 1'b1;
        pend_valid_d = 1'b0;
        fin_d        = (err_q == i2p_pkg::ErrNone);
      end else if (err_q != i2p_pkg::ErrNone || last_q) begin
        out_wr = 1'b1;
        fin_d  = 1'b1;
      end
    end
    err_out_d = fin_d ? err_q : i2p_pkg::ErrNone;
  end

  always_ff @(posedge clk_i) begin
    pend_char_q <= pend_char_d;
    if (out_wr) begin
      out_char_q   <= out_char_d;
      char_valid_q <= char_valid_d;
      fin_q        <= fin_d;
      done_q       <= fin_d && last_q;
      err_out_q    <= err_out_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_char_o   = out_char_q;
  assign char_valid_o = char_valid_q;
  assign run_last_o   = fin_q;
  assign expr_done_o  = done_q;
  assign err_code_o   = err_out_q;

  always_comb begin
    stat_o.kind       = i2p_pkg::kind_of(held_q);
    stat_o.last       = last_q;
    stat_o.cnt_zero   = (cnt_q == '0);
    stat_o.top_open   = (top_q == i2p_pkg::ChOpen);
    stat_o.prec_ge    = (i2p_pkg::prec_of(top_q) >= i2p_pkg::prec_of(held_q));
    stat_o.pend_valid = pend_valid_q;
    stat_o.out_free   = out_free;
    stat_o.fin_more   = pend_valid_q && (err_q != i2p_pkg::ErrNone);
  end

endmodule

@@ hdl/i2p_ctrl.sv @@
module i2p_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  i2p_pkg::stat_t  stat_i,
  output i2p_pkg::cmd_t   cmd_o
);

  typedef enum logic [2:0] {
    StIdle,
    StProc,
    StClose,
    StOpPop,
    StFin
  } state_e;

  state_e state_q, state_d;
  logic   emit_ok;

  assign emit_ok    = stat_i.out_free || !stat_i.pend_valid;
  assign in_stall_o = (state_q != StIdle);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StProc;
        end
      end
      StProc: begin
        case (stat_i.kind)
          i2p_pkg::ChrLetter: begin
            if (emit_ok) begin
              cmd_o.emit = 1'b1;
              state_d    = StFin;
            end
          end
          i2p_pkg::ChrPush: begin
            cmd_o.push = 1'b1;
            state_d    = StFin;
          end
          i2p_pkg::ChrClose: state_d = StClose;
          default:           state_d = StOpPop;
        endcase
      end
      StClose: begin
        if (stat_i.cnt_zero) begin
          cmd_o.unmatched = 1'b1;
          state_d         = StFin;
        end else if (stat_i.top_open) begin
          cmd_o.pop = 1'b1;
          state_d   = StFin;
        end else if (emit_ok) begin
          cmd_o.pop      = 1'b1;
          cmd_o.emit     = 1'b1;
          cmd_o.emit_top = 1'b1;
        end
      end
      StOpPop: begin
        if (!stat_i.cnt_zero && !stat_i.top_open && stat_i.prec_ge) begin
          if (emit_ok) begin
            cmd_o.pop      = 1'b1;
            cmd_o.emit     = 1'b1;
            cmd_o.emit_top = 1'b1;
          end
        end else begin
          cmd_o.push = 1'b1;
          state_d    = StFin;
        end
      end
      StFin: begin
        if (stat_i.last && !stat_i.cnt_zero) begin
          if (stat_i.top_open) begin
            cmd_o.pop = 1'b1;
          end else if (emit_ok) begin
            cmd_o.pop      = 1'b1;
            cmd_o.emit     = 1'b1;
            cmd_o.emit_top = 1'b1;
          end
        end else if (stat_i.out_free) begin
          cmd_o.fin = 1'b1;
          if (!stat_i.fin_more) begin
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ hdl/infix_to_postfix_converter_core.sv @@
// channel  direction  handshake             payload
// in       input      in_valid_i/in_stall_o   in_char_i, in_last_i
// out      output     out_valid_o/out_stall_i out_char_o, char_valid_o, run_last_o,
//                                             expr_done_o, err_code_o
//
// one input word at a time: in_stall_o stays high from acceptance until the controller
// is idle again, after any operators popped and emitted and any entries the flush pops;
// the pop loop in the controller pops one entry per cycle while the output is free, and
// close adds a word when a held-back character and an error word must both go out
// rst_ni is asynchronous, active low; clears the stack count, flags and output valid
// an output stall holds the output register and pauses the pop loop, input stays stalled
module infix_to_postfix_converter_core #(
  parameter int unsigned StackDepth = i2p_pkg::StackDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_char_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_char_o,
  output logic       char_valid_o,
  output logic       run_last_o,
  output logic       expr_done_o,
  output logic [1:0] err_code_o
);

  // command and status between sequencer and datapath
  i2p_pkg::cmd_t  cmd;
  i2p_pkg::stat_t stat;

  // sequencer: accept, classify, pop loops, end-of-item flush and close
  i2p_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // datapath: held word, operator stack with cached top, pending word, output register
  i2p_dp #(
    .StackDepth (StackDepth)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_char_i    (in_char_i),
    .in_last_i    (in_last_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .out_char_o   (out_char_o),
    .char_valid_o (char_valid_o),
    .run_last_o   (run_last_o),
    .expr_done_o  (expr_done_o),
    .err_code_o   (err_code_o)
  );

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  // one postfix word as seen on the output channel
  typedef struct packed {
    logic [7:0]    ch;
    logic          cv;
    logic          rl;
    logic          done;
    i2p_pkg::err_e err;
  } pf_word_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } in_word_t;

  typedef struct packed {
    in_word_t stim;
    bit       typed;
    pf_word_t want;
  } dir_row_t;

  localparam int unsigned RandItems = 430;
  localparam int unsigned DrainCycles = 100;
  localparam int NumDir = 26;

  // typed rows hold a single expected word, the rest go through the predictor
  localparam dir_row_t DirRows [NumDir] = '{
    '{'{i2p_pkg::ChClose, 1'b0}, 1'b1,
      '{8'h00, 1'b0, 1'b1, 1'b0, i2p_pkg::ErrUnmatched}},
    '{'{i2p_pkg::ChLowA,  1'b0}, 1'b1,
      '{i2p_pkg::ChLowA, 1'b1, 1'b1, 1'b0, i2p_pkg::ErrNone}},
    '{'{i2p_pkg::ChLowZ,  1'b1}, 1'b1,
      '{i2p_pkg::ChLowZ, 1'b1, 1'b1, 1'b1, i2p_pkg::ErrNone}},
    '{'{8'h00,   1'b0}, 1'b0, '0},
    '{'{8'hFF,   1'b1}, 1'b0, '0},
    '{'{i2p_pkg::ChOpen,  1'b1}, 1'b1,
      '{8'h00, 1'b0, 1'b1, 1'b1, i2p_pkg::ErrNone}},
    '{'{i2p_pkg::ChOpen,  1'b0}, 1'b0, '0},
    '{'{"a",     1'b0}, 1'b0, '0},
    '{'{i2p_pkg::ChPlus,  1'b0}, 1'b0, '0},
    '{'{"b",     1'b0}, 1'b0, '0},
    '{'{i2p_pkg::ChClose, 1'b0}, 1'b0, '0},
    '{'{i2p_pkg::ChCaret, 1'b0}, 1'b0, '0},
    '{'{"c",     1'b0}, 1'b0, '0},
    '{'{i2p_pkg::ChCaret, 1'b0}, 1'b0, '0},
    '{'{"d",     1'b0}, 1'b0, '0},
    '{'{i2p_pkg::ChStar,  1'b0}, 1'b0, '0},
    '{'{"e",     1'b0}, 1'b0, '0},
    '{'{i2p_pkg::ChSlash, 1'b0}, 1'b0, '0},
    '{'{"f",     1'b0}, 1'b0, '0},
    '{'{i2p_pkg::ChPct,   1'b0}, 1'b0, '0},
    '{'{"g",     1'b0}, 1'b0, '0},
    '{'{i2p_pkg::ChAmp,   1'b0}, 1'b0, '0},
    '{'{"h",     1'b0}, 1'b0, '0},
    '{'{i2p_pkg::ChMinus, 1'b0}, 1'b0, '0},
    '{'{"i",     1'b0}, 1'b0, '0},
    // stray close paren ends the expression: pops all, then error word
    '{'{i2p_pkg::ChClose, 1'b1}, 1'b0, '0}
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_char = 8'h00;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_char;
  logic       char_valid;
  logic       run_last;
  logic       expr_done;
  logic [1:0] err_code;

  pf_word_t    expected_words[$];
  in_word_t    stim_q[$];
  logic [7:0]  op_stk [i2p_pkg::StackDepth];
  int unsigned op_cnt = 0;
  int unsigned mismatches = 0;
  int unsigned random_items = 0;
  bit          in_burst = 1'b0;
  bit          out_burst = 1'b0;

  infix_to_postfix_converter_core u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_char_i   (in_char),
    .in_last_i   (in_last),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_char_o  (out_char),
    .char_valid_o(char_valid),
    .run_last_o  (run_last),
    .expr_done_o (expr_done),
    .err_code_o  (err_code)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("infix_to_postfix_converter_core test failed");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int unsigned rank_of(logic [7:0] c);
    case (c)
      i2p_pkg::ChCaret, i2p_pkg::ChAmp:                  return 4;
      i2p_pkg::ChStar, i2p_pkg::ChSlash, i2p_pkg::ChPct: return 3;
      i2p_pkg::ChPlus, i2p_pkg::ChMinus:                 return 2;
      default:                                           return 1;
    endcase
  endfunction

  function automatic i2p_pkg::err_e push_op(logic [7:0] c);
    if (op_cnt >= i2p_pkg::StackDepth) return i2p_pkg::ErrOverflow;
    op_stk[op_cnt] = c;
    op_cnt++;
    return i2p_pkg::ErrNone;
  endfunction

  function automatic void emit_char(logic [7:0] c);
    expected_words.push_back('{c, 1'b1, 1'b0, 1'b0, i2p_pkg::ErrNone});
  endfunction

  function automatic void postfix_step(logic [7:0] c, logic last);
    i2p_pkg::err_e err;
    int unsigned   n0;
    int unsigned   p;
    bit            matched;
    err = i2p_pkg::ErrNone;
    n0 = expected_words.size();
    if (c >= i2p_pkg::ChLowA && c <= i2p_pkg::ChLowZ) begin
      emit_char(c);
    end else if (c == i2p_pkg::ChOpen || c == i2p_pkg::ChCaret) begin
      err = push_op(c);
    end else if (c == i2p_pkg::ChClose) begin
      matched = 1'b0;
      while (op_cnt > 0 && !matched) begin
        op_cnt--;
        if (op_stk[op_cnt] == i2p_pkg::ChOpen) matched = 1'b1;
        else emit_char(op_stk[op_cnt]);
      end
      if (!matched) err = i2p_pkg::ErrUnmatched;
    end else begin
      p = rank_of(c);
      while (op_cnt > 0 && op_stk[op_cnt-1] != i2p_pkg::ChOpen &&
             rank_of(op_stk[op_cnt-1]) >= p) begin
        op_cnt--;
        emit_char(op_stk[op_cnt]);
      end
      err = push_op(c);
    end
    // end of expression: flush, open parens vanish
    if (last) begin
      while (op_cnt > 0) begin
        op_cnt--;
        if (op_stk[op_cnt] != i2p_pkg::ChOpen) emit_char(op_stk[op_cnt]);
      end
    end
    if (err != i2p_pkg::ErrNone || (last && expected_words.size() == n0)) begin
      expected_words.push_back('{8'h00, 1'b0, 1'b0, 1'b0, i2p_pkg::ErrNone});
    end
    if (expected_words.size() > n0) begin
      expected_words[expected_words.size()-1].rl = 1'b1;
      expected_words[expected_words.size()-1].done = last;
      expected_words[expected_words.size()-1].err = err;
    end
  endfunction

  // ---------------------------------------------------------------- handshakes

  function automatic int unsigned draw_gap(inout bit burst);
    if ($urandom_range(0, 39) == 0) burst = !burst;
    return burst ? 0 : $urandom_range(0, 5);
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_word(in_word_t w, bit typed, pf_word_t want);
    int unsigned g;
    int unsigned n0;
    g = draw_gap(in_burst);
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_char <= w.ch;
    in_last <= w.last;
    do @(posedge clk); while (in_stall);
    n0 = expected_words.size();
    postfix_step(w.ch, w.last);
    if (typed) begin
      while (expected_words.size() > n0) void'(expected_words.pop_back());
      expected_words.push_back(want);
    end
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (expected_words.size() != 0) @(negedge clk);
  endtask

  // receiver stall, one gap per word
  initial begin
    int unsigned g;
    forever begin
      @(negedge clk);
      g = draw_gap(out_burst);
      if (g != 0) begin
        out_stall <= 1'b1;
        repeat (g) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(rst_n && out_valid));
    end
  end

  // scoreboard against the oldest expected word
  always @(posedge clk) begin
    pf_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("word with nothing expected: ch=%h cv=%b rl=%b done=%b err=%0d",
                   out_char, char_valid, run_last, expr_done, err_code);
      end else begin
        want = expected_words.pop_front();
        if (out_char !== want.ch || char_valid !== want.cv || run_last !== want.rl ||
            expr_done !== want.done || err_code !== want.err) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: want ch/cv/rl/done/err %h/%b/%b/%b/%0d, got %h/%b/%b/%b/%0d",
                     want.ch, want.cv, want.rl, want.done, want.err,
                     out_char, char_valid, run_last, expr_done, err_code);
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic logic [7:0] rand_letter();
    return i2p_pkg::ChLowA + 8'($urandom_range(0, 25));
  endfunction

  // precedence-1 operators: upper case, digits, controls and blank, high bytes
  function automatic logic [7:0] rand_other();
    case ($urandom_range(0, 3))
      0:       return 8'h41 + 8'($urandom_range(0, 25));
      1:       return 8'h30 + 8'($urandom_range(0, 9));
      2:       return 8'($urandom_range(0, 32));
      default: return 8'h80 + 8'($urandom_range(0, 127));
    endcase
  endfunction

  function automatic logic [7:0] rand_op();
    case ($urandom_range(0, 9))
      0:       return i2p_pkg::ChCaret;
      1:       return i2p_pkg::ChAmp;
      2:       return i2p_pkg::ChStar;
      3:       return i2p_pkg::ChSlash;
      4:       return i2p_pkg::ChPct;
      5:       return i2p_pkg::ChPlus;
      6:       return i2p_pkg::ChMinus;
      7:       return rand_other();
      8:       return i2p_pkg::ChPlus;
      default: return i2p_pkg::ChStar;
    endcase
  endfunction

  task automatic build_expr(int unsigned n_opnd, int unsigned max_open);
    int unsigned depth;
    int unsigned k;
    depth = 0;
    for (int unsigned i = 0; i < n_opnd; i++) begin
      if (i > 0) stim_q.push_back('{rand_op(), 1'b0});
      k = $urandom_range(0, 2);
      if (depth + k > max_open) k = max_open - depth;
      repeat (k) stim_q.push_back('{i2p_pkg::ChOpen, 1'b0});
      depth += k;
      stim_q.push_back('{rand_letter(), 1'b0});
      if (depth > 0) begin
        k = $urandom_range(0, depth);
        repeat (k) stim_q.push_back('{i2p_pkg::ChClose, 1'b0});
        depth -= k;
      end
    end
    // sometimes leave parens open for the flush to drop
    if ($urandom_range(0, 3) != 0) begin
      repeat (depth) stim_q.push_back('{i2p_pkg::ChClose, 1'b0});
    end
  endtask

  // pushes StackDepth-1 to StackDepth+3 of '(' and '^', so the stack fills and may overflow
  task automatic build_overflow();
    int unsigned target;
    int unsigned pushes;
    target = $urandom_range(i2p_pkg::StackDepth - 1, i2p_pkg::StackDepth + 3);
    pushes = 0;
    while (pushes < target) begin
      if ($urandom_range(0, 4) == 0) begin
        stim_q.push_back('{rand_letter(), 1'b0});
      end else begin
        stim_q.push_back('{($urandom_range(0, 1) != 0) ? i2p_pkg::ChOpen : i2p_pkg::ChCaret,
                           1'b0});
        pushes++;
      end
    end
    repeat ($urandom_range(1, 3)) begin
      stim_q.push_back('{rand_op(), 1'b0});
      stim_q.push_back('{rand_letter(), 1'b0});
    end
    if ($urandom_range(0, 1) != 0) stim_q.push_back('{i2p_pkg::ChClose, 1'b0});
  endtask

  task automatic build_noise();
    repeat ($urandom_range(1, 8)) begin
      stim_q.push_back('{8'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0)});
    end
  endtask

  task automatic build_broken();
    int unsigned pos;
    build_expr($urandom_range(2, 6), 3);
    pos = $urandom_range(0, stim_q.size() - 1);
    case ($urandom_range(0, 2))
      0:       stim_q.insert(pos, '{i2p_pkg::ChClose, 1'b0});
      1:       stim_q[pos].ch = 8'($urandom_range(0, 255));
      default: stim_q.delete(pos);
    endcase
  endtask

  initial begin
    int unsigned kind;
    bit          first;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NumDir; i++) begin
      send_word(DirRows[i].stim, DirRows[i].typed, DirRows[i].want);
    end
    // sender holds off until the output side has caught up
    wait_drained();

    first = 1'b1;
    while (random_items < RandItems) begin
      stim_q.delete();
      kind = first ? 9 : $urandom_range(0, 9);
      first = 1'b0;
      case (kind)
        6: build_expr($urandom_range(1, 4), 2);  // runs on into the next expression
        7: build_broken();
        8: build_noise();
        9: build_overflow();
        default: build_expr($urandom_range(1, 8), 4);
      endcase
      if (kind != 6 && kind != 8 && stim_q.size() != 0 &&
          (kind != 7 || $urandom_range(0, 3) != 0)) begin
        stim_q[stim_q.size()-1].last = 1'b1;
      end
      foreach (stim_q[i]) begin
        send_word(stim_q[i], 1'b0, '0);
        random_items++;
      end
      if ($urandom_range(0, 11) == 0) wait_drained();
    end

    wait_drained();
    repeat (DrainCycles) @(negedge clk);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("infix_to_postfix_converter_core test passed");
    end else begin
      $display("infix_to_postfix_converter_core test failed");
    end
    $finish;
  end

endmodule

@@ infix_to_postfix_converter_core.f @@
hdl/i2p_pkg.sv
hdl/i2p_dp.sv
hdl/i2p_ctrl.sv
hdl/infix_to_postfix_converter_core.sv
tb/tb_top.sv
